// ===== rtl/core/deepest_contact_retention_table_defines.svh =====
// assertion macros used by the checker file
`ifndef DEEPEST_CONTACT_RETENTION_TABLE_DEFINES_SVH
`define DEEPEST_CONTACT_RETENTION_TABLE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define DCRT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define DCRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dcrt_pkg.sv =====
package dcrt_pkg;

    localparam int DEPTH_W       = 32;
    localparam int LIMIT_W       = 5;
    localparam int SLOT_OUT_W    = 4;
    localparam int MAX_SLOTS_DEF = 16;

    typedef logic signed [DEPTH_W-1:0] depth_t;
    typedef logic [LIMIT_W-1:0]        limit_t;
    typedef logic [SLOT_OUT_W-1:0]     slot_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_DECIDE
    } state_t;

    // control from the sequencer to the minimum search unit
    typedef struct packed {
        logic issue;
        logic first;
    } scan_ctl_t;

endpackage

// ===== rtl/core/dcrt_depth_ram.sv =====
module dcrt_depth_ram
    import dcrt_pkg::*;
#(
    parameter int DEPTH  = MAX_SLOTS_DEF,
    parameter int ADDR_W = 4
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  depth_t            wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output depth_t            rd_data
);

    depth_t mem [DEPTH];
    depth_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/dcrt_min_scan.sv =====
module dcrt_min_scan
    import dcrt_pkg::*;
#(
    parameter int SLOT_W = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  scan_ctl_t         ctl,
    input  logic [SLOT_W-1:0] idx,
    input  depth_t            rd_data,
    output depth_t            best_depth,
    output logic [SLOT_W-1:0] best_idx
);

    logic              vld_reg;
    logic              first_reg;
    logic [SLOT_W-1:0] idx_pipe_reg;
    depth_t            best_reg;
    logic [SLOT_W-1:0] best_idx_reg;
    logic              take;

    // read data comes from a registered read, so issue and first are registered to line up with it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            vld_reg   <= ctl.issue;
            first_reg <= ctl.first;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_pipe_reg <= idx;
    end

    // strict less-than keeps the lowest index on ties
    assign take = vld_reg && (first_reg || (rd_data < best_reg));

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_reg     <= rd_data;
            best_idx_reg <= idx_pipe_reg;
        end
    end

    assign best_depth = best_reg;
    assign best_idx   = best_idx_reg;

endmodule

// ===== rtl/core/deepest_contact_retention_table.sv =====
// channel   | handshake              | payload
// ----------+------------------------+--------------------------
// command   | start, busy            | mode, depth
// result    | done (one-cycle pulse) | stored, slot, replaced
// config    | cfg_valid, cfg_ready   | cfg_data (contact_limit)
//
// a clear item, a record with limit zero or a record into a free slot gives
// its result in the cycle after it is taken
// a record into a full table scans the kept slots through the single read port
// of the depth memory, one slot a cycle, up to the limit capped at MAX_SLOTS,
// then passes the tail and decide states before its result shows
// busy is high from the cycle after a scanned record is taken until its result shows
// done is a pulse the receiver cannot stall; rst_n clears the fill count,
// limit and sequencer, no clearing pass over the depth memory
module deepest_contact_retention_table
    import dcrt_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    output logic   busy,
    input  logic   mode,
    input  depth_t depth,
    output logic   done,
    output logic   stored,
    output slot_t  slot,
    output logic   replaced,
    input  logic   cfg_valid,
    output logic   cfg_ready,
    input  limit_t cfg_data
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int LW     = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  filled_reg, filled_next;
    limit_t            limit_reg;
    depth_t            depth_reg, depth_next;
    logic [SLOT_W-1:0] rd_idx_reg, rd_idx_next;
    logic              done_reg, done_next;
    logic              stored_reg, stored_next;
    slot_t             slot_reg, slot_next;
    logic              replaced_reg, replaced_next;

    logic [LW-1:0]     lim_wide;
    logic [CNT_W-1:0]  eff_limit;
    logic [CNT_W-1:0]  last_idx;
    logic              accept;
    logic              go_scan;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    depth_t            wr_data;
    logic              rd_en;
    depth_t            rd_data;
    scan_ctl_t         scan_ctl;
    depth_t            best_depth;
    logic [SLOT_W-1:0] best_idx;

    // limits above the table size saturate to it
    assign lim_wide  = LW'(limit_reg);
    assign eff_limit = (lim_wide > LW'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(lim_wide);
    assign last_idx  = eff_limit - CNT_W'(1);

    assign accept  = start && (state_reg == ST_IDLE);
    assign go_scan = accept && !mode && (eff_limit != '0) && (filled_reg >= eff_limit);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (go_scan)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_idx_reg == last_idx[SLOT_W-1:0])
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        filled_next    = filled_reg;
        depth_next     = depth_reg;
        rd_idx_next    = rd_idx_reg;
        done_next      = 1'b0;
        stored_next    = 1'b0;
        slot_next      = '0;
        replaced_next  = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = filled_reg[SLOT_W-1:0];
        wr_data        = depth;
        rd_en          = 1'b0;
        scan_ctl.issue = 1'b0;
        scan_ctl.first = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    depth_next  = depth;
                    rd_idx_next = '0;
                    if (mode)
                    begin
                        filled_next = '0;
                        done_next   = 1'b1;
                    end
                    else if (eff_limit == '0)
                    begin
                        done_next = 1'b1;
                    end
                    else if (filled_reg < eff_limit)
                    begin
                        wr_en       = 1'b1;
                        filled_next = filled_reg + CNT_W'(1);
                        done_next   = 1'b1;
                        stored_next = 1'b1;
                        slot_next   = SLOT_OUT_W'(filled_reg);
                    end
                end
            end
            ST_SCAN:
            begin
                rd_en          = 1'b1;
                scan_ctl.issue = 1'b1;
                scan_ctl.first = (rd_idx_reg == '0);
                rd_idx_next    = rd_idx_reg + SLOT_W'(1);
            end
            ST_TAIL:
            begin
            end
            ST_DECIDE:
            begin
                done_next = 1'b1;
                wr_addr   = best_idx;
                wr_data   = depth_reg;
                if (best_depth < depth_reg)
                begin
                    wr_en         = 1'b1;
                    stored_next   = 1'b1;
                    replaced_next = 1'b1;
                    slot_next     = SLOT_OUT_W'(best_idx);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            filled_reg <= '0;
            limit_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            filled_reg <= filled_next;
            done_reg   <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        depth_reg    <= depth_next;
        rd_idx_reg   <= rd_idx_next;
        stored_reg   <= stored_next;
        slot_reg     <= slot_next;
        replaced_reg <= replaced_next;
    end

    dcrt_depth_ram #(
        .DEPTH  (MAX_SLOTS),
        .ADDR_W (SLOT_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    dcrt_min_scan #(
        .SLOT_W (SLOT_W)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .idx        (rd_idx_reg),
        .rd_data    (rd_data),
        .best_depth (best_depth),
        .best_idx   (best_idx)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign done      = done_reg;
    assign stored    = stored_reg;
    assign slot      = slot_reg;
    assign replaced  = replaced_reg;

endmodule

// ===== rtl/core/dcrt_checker.sv =====
`include "deepest_contact_retention_table_defines.svh"

module dcrt_checker
    import dcrt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  busy,
    input  logic  mode,
    input  logic  done,
    input  logic  stored,
    input  slot_t slot,
    input  logic  replaced
);

    // a result only shows once the sequencer has let go
    `DCRT_ASSERT_NOW(a_done_not_busy, clk, rst_n, done, !busy, "result while busy")

    // a clear item answers at once with nothing stored
    `DCRT_ASSERT_NEXT(a_clear_result, clk, rst_n, start && !busy && mode, done && !stored && !busy, "clear item result wrong")

    `DCRT_ASSERT_NOW(a_replace_stores, clk, rst_n, done && replaced, stored, "replace without store")

    // a dropped item reports slot zero
    `DCRT_ASSERT_NOW(a_drop_zero, clk, rst_n, done && !stored, (slot == '0) && !replaced, "dropped item not zeroed")

    // every accepted item either answers next cycle or keeps the block busy
    `DCRT_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, done || busy, "accepted item lost")

endmodule

bind deepest_contact_retention_table dcrt_checker u_dcrt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .mode     (mode),
    .done     (done),
    .stored   (stored),
    .slot     (slot),
    .replaced (replaced)
);

// ===== bench/deepest_contact_retention_table_test.sv =====
module deepest_contact_retention_table_test;
    import dcrt_pkg::*;

    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;
    localparam int   CYCLE_LIMIT = 400000;
    localparam int   RANDOM_ITEMS = 700;
    localparam int   SETTLE_CYCLES = 25;
    localparam int   MAX_PRINTS = 50;

    typedef struct packed {
        logic  stored;
        slot_t slot;
        logic  replaced;
    } outcome_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    logic   mode = MODE_RECORD;
    depth_t depth = '0;
    logic   done;
    logic   stored;
    slot_t  slot;
    logic   replaced;
    logic   cfg_valid = 1'b0;
    logic   cfg_ready;
    limit_t cfg_data = '0;

    // shadow of the block: kept depths, fill count and limit
    depth_t depth_mem [MAX_SLOTS_DEF];
    int     fill_count = 0;
    limit_t cur_limit = '0;

    outcome_t expected_outcomes [$];
    int       mismatches = 0;
    int       cycle_count = 0;
    int       burst_left = 0;

    deepest_contact_retention_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .mode      (mode),
        .depth     (depth),
        .done      (done),
        .stored    (stored),
        .slot      (slot),
        .replaced  (replaced),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic outcome_t predict_contact(logic m, depth_t d);
        outcome_t o;
        int       lim;
        int       best;
        int       i;
        depth_t   best_d;
        o = '0;
        lim = (cur_limit > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : int'(cur_limit);
        if (m == MODE_CLEAR)
            fill_count = 0;
        else if (lim != 0)
        begin
            if (fill_count < lim)
            begin
                o.slot = slot_t'(fill_count);
                o.stored = 1'b1;
                depth_mem[fill_count] = d;
                fill_count++;
            end
            else
            begin
                // shallowest kept entry below the limit, lowest index on ties
                best = 0;
                best_d = depth_mem[0];
                for (i = 1; i < lim; i++)
                    if (depth_mem[i] < best_d)
                    begin
                        best_d = depth_mem[i];
                        best = i;
                    end
                if (best_d < d)
                begin
                    depth_mem[best] = d;
                    o.slot = slot_t'(best);
                    o.stored = 1'b1;
                    o.replaced = 1'b1;
                end
            end
        end
        return o;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n && done)
        begin
            if (expected_outcomes.size() == 0)
                report_mismatch($sformatf("unexpected result stored=%0b slot=%0d replaced=%0b",
                                          stored, slot, replaced));
            else
            begin
                want = expected_outcomes.pop_front();
                if (stored !== want.stored)
                    report_mismatch($sformatf("stored %0b, want %0b", stored, want.stored));
                if (slot !== want.slot)
                    report_mismatch($sformatf("slot %0d, want %0d", slot, want.slot));
                if (replaced !== want.replaced)
                    report_mismatch($sformatf("replaced %0b, want %0b",
                                              replaced, want.replaced));
            end
        end
    end

    task automatic send_item(input logic m, input depth_t d);
        @(negedge clk);
        start <= 1'b1;
        mode <= m;
        depth <= d;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_outcomes.insert(expected_outcomes.size(), predict_contact(m, d));
    endtask

    task automatic pause_sender(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // bursts of back-to-back items separated by random gaps
    task automatic send_paced(input logic m, input depth_t d);
        send_item(m, d);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            pause_sender($urandom_range(0, 3) == 0 ? $urandom_range(1, 24) :
                                                     $urandom_range(1, 4));
            burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(0, 20);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input limit_t v);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cur_limit = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic depth_t random_depth();
        case ($urandom_range(0, 9))
            5, 6, 7: return depth_t'($urandom_range(0, 8) - 4);
            8:       return depth_t'(32'h8000_0000 + $urandom_range(0, 2));
            9:       return depth_t'(32'h7FFF_FFFF - $urandom_range(0, 2));
            default: return depth_t'($urandom);
        endcase
    endfunction

    // limit still at its reset value of zero
    task automatic test_reporting_disabled();
        send_item(MODE_RECORD, 32'sh7FFF_FFFF);
        send_item(MODE_RECORD, 32'sh8000_0000);
        send_item(MODE_CLEAR, '1);
    endtask

    task automatic test_fill_and_replace();
        write_limit(limit_t'(4));
        send_item(MODE_CLEAR, '0);
        send_item(MODE_RECORD, 32'sh8000_0000);
        send_item(MODE_RECORD, 32'sh7FFF_FFFF);
        send_item(MODE_RECORD, 32'sh0000_0000);
        send_item(MODE_RECORD, -32'sd1);
        // equal to the shallowest: dropped
        send_item(MODE_RECORD, 32'sh8000_0000);
        send_item(MODE_RECORD, 32'sh8000_0001);
        send_item(MODE_RECORD, 32'sh0000_0000);
        send_item(MODE_RECORD, 32'sh0000_0005);
        // two slots tie at zero, first one goes
        send_item(MODE_RECORD, 32'sh0000_0001);
        send_item(MODE_RECORD, 32'sh0000_0001);
    endtask

    task automatic test_limit_changes_mid_step();
        // lowered below the fill count: only the low slots are searched
        write_limit(limit_t'(2));
        send_item(MODE_RECORD, 32'sh7FFF_FFFF);
        send_item(MODE_RECORD, 32'sh0000_0002);
        // raised past the fill count: free slots again
        write_limit(limit_t'(16));
        send_item(MODE_RECORD, 32'sh1234_5678);
        send_item(MODE_CLEAR, 32'shFFFF_FFFF);
        send_item(MODE_RECORD, 32'shEDCB_A987);
    endtask

    task automatic test_random_traffic();
        int     sent;
        int     phase_len;
        int     k;
        bit     noisy;
        limit_t lim;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 6))
                0:       lim = limit_t'(0);
                1:       lim = limit_t'(1);
                2:       lim = limit_t'(16);
                3:       lim = limit_t'(31);
                default: lim = limit_t'($urandom_range(0, 31));
            endcase
            // also the pause of the sender until everything has come back
            write_limit(lim);
            phase_len = $urandom_range(20, 80);
            noisy = ($urandom_range(0, 3) == 0);
            if (!noisy && $urandom_range(0, 3) != 0)
            begin
                send_paced(MODE_CLEAR, depth_t'($urandom));
                sent++;
            end
            for (k = 0; k < phase_len; k++)
            begin
                if (noisy)
                    send_paced(logic'($urandom_range(0, 1)), random_depth());
                else if ($urandom_range(0, 39) == 0)
                    send_paced(MODE_CLEAR, depth_t'($urandom));
                else
                    send_paced(MODE_RECORD, random_depth());
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reporting_disabled();
        test_fill_and_replace();
        test_limit_changes_mid_step();
        test_random_traffic();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_outcomes.size() != 0)
            report_mismatch($sformatf("%0d results never came", expected_outcomes.size()));
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
